[rtl/core/mlfd_pkg.sv]
// Package for the marker/length frame deframer.
// Holds the framing constants, the emitter state type and the frame-done struct.
// No dependencies.
package mlfd_pkg;

    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] END_BYTE   = 8'hFF;
    localparam int unsigned HEAD_LEN  = 4;
    localparam int unsigned TAIL_LEN  = 2;
    localparam logic [7:0] MIN_LEN    = 8'(HEAD_LEN + TAIL_LEN);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_EMPTY
    } t_emit_state;

    typedef struct packed {
        logic       start;
        logic [7:0] ftype;
        logic [7:0] fid;
        logic [7:0] npay;
    } t_frame_info;

endpackage

[rtl/core/mlfd_store.sv]
// Frame byte store: one write port, one read port with registered read data.
// Depends on nothing.
module mlfd_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/mlfd_collect.sv]
// Receive side: counts bytes, tracks length, sum, checksum, type and id,
// writes bytes to the store and flags a good frame. Uses mlfd_pkg.
module mlfd_collect #(
    parameter int unsigned MAX_FRAME = 64,
    parameter int unsigned AW        = $clog2(MAX_FRAME)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_acc,
    input  logic [7:0]           i_byte,
    output logic                 o_wr_en,
    output logic [AW-1:0]        o_wr_addr,
    output mlfd_pkg::t_frame_info o_info
);

    logic [8:0] r_count, n_count;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_len, n_len;
    logic [7:0] r_ck, n_ck;
    logic [7:0] r_type, n_type;
    logic [7:0] r_id, n_id;

    logic [8:0] cnt0, cnt1;
    logic [7:0] sum0, sum1;
    logic [7:0] len_eff;
    logic       is_end, done, good, clear;

    always_comb begin
        cnt0    = (i_byte == mlfd_pkg::START_BYTE) ? 9'd0 : r_count;
        sum0    = (i_byte == mlfd_pkg::START_BYTE) ? 8'd0 : r_sum;
        cnt1    = cnt0 + 9'd1;
        sum1    = sum0 + i_byte;
        len_eff = (cnt0 == 9'd1) ? i_byte : r_len;
        is_end  = (i_byte == mlfd_pkg::END_BYTE);
        done    = (cnt1 > 9'd1) && is_end && (cnt1 == {1'b0, len_eff});
        good    = done && (len_eff >= mlfd_pkg::MIN_LEN)
                  && ({1'b0, len_eff} <= 9'(MAX_FRAME))
                  && (sum1 == {r_ck[6:0], 1'b0});
        clear   = is_end || ((cnt1 > 9'd1) && (cnt1 > {1'b0, len_eff}));

        n_count = r_count;
        n_sum   = r_sum;
        n_len   = r_len;
        n_ck    = r_ck;
        n_type  = r_type;
        n_id    = r_id;
        if (i_acc) begin
            n_count = clear ? 9'd0 : cnt1;
            n_sum   = clear ? 8'd0 : sum1;
            if (cnt0 == 9'd1) begin
                n_len = i_byte;
            end
            if (cnt0 == 9'd2) begin
                n_type = i_byte;
            end
            if (cnt0 == 9'd3) begin
                n_id = i_byte;
            end
            if ((cnt1 + 9'd1) == {1'b0, len_eff}) begin
                n_ck = i_byte;
            end
        end

        o_wr_en       = i_acc && (cnt0 < 9'(MAX_FRAME));
        o_wr_addr     = cnt0[AW-1:0];
        o_info.start  = i_acc && good;
        o_info.ftype  = r_type;
        o_info.fid    = r_id;
        o_info.npay   = len_eff - mlfd_pkg::MIN_LEN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
        r_len  <= n_len;
        r_ck   <= n_ck;
        r_type <= n_type;
        r_id   <= n_id;
    end

endmodule

[rtl/core/mlfd_emit.sv]
// Result side: reads payload bytes from the store and drives the output register.
// Uses mlfd_pkg.
module mlfd_emit #(
    parameter int unsigned AW = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mlfd_pkg::t_frame_info i_info,
    output logic                  o_busy,
    output logic                  o_rd_en,
    output logic [AW-1:0]         o_rd_addr,
    input  logic [7:0]            i_rd_data,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic [7:0]            o_frame_type,
    output logic [7:0]            o_frame_id,
    output logic [7:0]            o_payload_byte,
    output logic                  o_has_payload,
    output logic                  o_last_of_frame
);

    mlfd_pkg::t_emit_state r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic [7:0]    r_left, n_left;
    logic [7:0]    r_type, n_type;
    logic [7:0]    r_id, n_id;
    logic          r_valid, n_valid;
    logic [7:0]    r_pay, n_pay;
    logic          r_has, n_has;
    logic          r_last, n_last;
    logic [7:0]    r_otype, n_otype;
    logic [7:0]    r_oid, n_oid;
    logic          out_free;

    always_comb begin
        out_free = !r_valid || !i_stall;
        n_state  = r_state;
        n_addr   = r_addr;
        n_left   = r_left;
        n_type   = r_type;
        n_id     = r_id;
        n_valid  = r_valid && i_stall;
        n_pay    = r_pay;
        n_has    = r_has;
        n_last   = r_last;
        n_otype  = r_otype;
        n_oid    = r_oid;
        o_rd_en  = 1'b0;

        unique case (r_state)
            mlfd_pkg::ST_IDLE: begin
                if (i_info.start) begin
                    n_type  = i_info.ftype;
                    n_id    = i_info.fid;
                    n_left  = i_info.npay;
                    n_addr  = AW'(mlfd_pkg::HEAD_LEN);
                    n_state = (i_info.npay == 8'd0) ? mlfd_pkg::ST_EMPTY
                                                    : mlfd_pkg::ST_READ;
                end
            end
            mlfd_pkg::ST_READ: begin
                if (out_free) begin
                    o_rd_en = 1'b1;
                    n_state = mlfd_pkg::ST_LOAD;
                end
            end
            mlfd_pkg::ST_LOAD: begin
                n_valid = 1'b1;
                n_otype = r_type;
                n_oid   = r_id;
                n_pay   = i_rd_data;
                n_has   = 1'b1;
                n_last  = (r_left == 8'd1);
                n_left  = r_left - 8'd1;
                n_addr  = r_addr + AW'(1);
                n_state = (r_left == 8'd1) ? mlfd_pkg::ST_IDLE : mlfd_pkg::ST_READ;
            end
            mlfd_pkg::ST_EMPTY: begin
                if (out_free) begin
                    n_valid = 1'b1;
                    n_otype = r_type;
                    n_oid   = r_id;
                    n_pay   = 8'd0;
                    n_has   = 1'b0;
                    n_last  = 1'b1;
                    n_state = mlfd_pkg::ST_IDLE;
                end
            end
            default: n_state = mlfd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlfd_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_addr  <= n_addr;
        r_left  <= n_left;
        r_type  <= n_type;
        r_id    <= n_id;
        r_pay   <= n_pay;
        r_has   <= n_has;
        r_last  <= n_last;
        r_otype <= n_otype;
        r_oid   <= n_oid;
    end

    assign o_busy          = (r_state != mlfd_pkg::ST_IDLE);
    assign o_rd_addr       = r_addr;
    assign o_valid         = r_valid;
    assign o_frame_type    = r_otype;
    assign o_frame_id      = r_oid;
    assign o_payload_byte  = r_pay;
    assign o_has_payload   = r_has;
    assign o_last_of_frame = r_last;

endmodule

[rtl/core/marker_length_frame_deframer.sv]
// Marker/length frame deframer top level: collector, frame store, emitter.
// Takes one byte per cycle while no frame is being emitted. For a good frame the emitter
// reads each payload byte from the store, then loads it into the output register; an empty
// frame gives one result with no payload. A new store read waits while the output is stalled.
// The input is stalled once the frame's closing byte is taken until its last result is loaded.
// Synchronous active-low reset clears counters, emitter state and output valid;
// the store contents are not cleared. Uses mlfd_pkg, mlfd_store, mlfd_collect, mlfd_emit.
module marker_length_frame_deframer #(
    parameter int unsigned MAX_FRAME = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_frame_type,
    output logic [7:0] o_frame_id,
    output logic [7:0] o_payload_byte,
    output logic       o_has_payload,
    output logic       o_last_of_frame
);

    localparam int unsigned AW = $clog2(MAX_FRAME);

    logic                  acc;
    logic                  busy;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [7:0]            rd_data;
    mlfd_pkg::t_frame_info info;

    assign o_stall = busy;
    assign acc     = i_valid && !busy;

    mlfd_collect #(.MAX_FRAME(MAX_FRAME), .AW(AW)) u_collect (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_byte    (i_rx_byte),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_info    (info)
    );

    mlfd_store #(.DEPTH(MAX_FRAME), .AW(AW)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    mlfd_emit #(.AW(AW)) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_info          (info),
        .o_busy          (busy),
        .o_rd_en         (rd_en),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_frame_type    (o_frame_type),
        .o_frame_id      (o_frame_id),
        .o_payload_byte  (o_payload_byte),
        .o_has_payload   (o_has_payload),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

[rtl/core/mlfd_checker.sv]
// Port-level checks for the marker/length frame deframer, bound to the top level.
// Depends on marker_length_frame_deframer.
module mlfd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_frame_type,
    input logic [7:0] o_frame_id,
    input logic [7:0] o_payload_byte,
    input logic       o_has_payload,
    input logic       o_last_of_frame
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_payload_byte)
                               && $stable(o_last_of_frame) && $stable(o_frame_type))
        else $error("stalled result beat changed");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_payload |-> o_last_of_frame && (o_payload_byte == 8'd0))
        else $error("empty-frame beat malformed");

    a_same_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_of_frame |=>
            $stable(o_frame_type) && $stable(o_frame_id))
        else $error("type or id changed inside a frame");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat valid after reset");

endmodule

bind marker_length_frame_deframer mlfd_checker u_mlfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_frame_type    (o_frame_type),
    .o_frame_id      (o_frame_id),
    .o_payload_byte  (o_payload_byte),
    .o_has_payload   (o_has_payload),
    .o_last_of_frame (o_last_of_frame)
);
